### rtl/core/pbr_pkg.sv
package pbr_pkg;

   // Operation codes carried in the request word.
   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_READ   = 2'd1,
      OP_LOOKUP = 2'd2
   } pbr_op_type;

   localparam int COLOR_W = 16;
   localparam int CHAN_W  = 8;
   localparam int INDEX_W = 8;
   localparam int COUNT_W = 9;

   // RGB888 to RGB565 truncation masks.
   localparam logic [CHAN_W-1:0] RB_MASK = 8'hF8;
   localparam logic [CHAN_W-1:0] G_MASK  = 8'hFC;

   typedef struct packed {
      logic [1:0]         operation;
      logic [CHAN_W-1:0]  red;
      logic [CHAN_W-1:0]  green;
      logic [CHAN_W-1:0]  blue;
      logic [INDEX_W-1:0] entry_index;
      logic [COLOR_W-1:0] lookup_color;
   } pbr_req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] palette_index;
      logic               matched;
      logic               added;
      logic               dropped;
      logic [COLOR_W-1:0] entry_color;
      logic [COUNT_W-1:0] entry_count;
   } pbr_rsp_type;

   // Query token that walks the cell chain, one cell per cycle.
   typedef struct packed {
      logic               valid;
      logic [1:0]         op;
      logic [COLOR_W-1:0] key;
      logic [INDEX_W-1:0] read_idx;
      logic               matched;
      logic               added;
      logic [COLOR_W-1:0] color;
   } pbr_token_type;

endpackage

### rtl/core/pbr_cell.sv
module pbr_cell import pbr_pkg::*; #(
   parameter int IDX_W    = 8,
   parameter int CNT_W    = 9,
   parameter int CELL_IDX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [CNT_W-1:0]    count,
   input  pbr_token_type       up_tok,
   input  logic [IDX_W-1:0]    up_slot,
   output pbr_token_type       dn_tok,
   output logic [IDX_W-1:0]    dn_slot
);

   localparam logic [CNT_W-1:0]       MY_POS  = CNT_W'(CELL_IDX);
   localparam logic [IDX_W-1:0]       MY_SLOT = IDX_W'(CELL_IDX);
   localparam logic [CNT_W+INDEX_W-1:0] MY_RD = (CNT_W+INDEX_W)'(CELL_IDX);

   logic [COLOR_W-1:0] color_ff;
   logic [COLOR_W-1:0] color_in;
   pbr_token_type      tok_ff;
   pbr_token_type      tok_in;
   logic [IDX_W-1:0]   slot_ff;
   logic [IDX_W-1:0]   slot_in;

   logic occupied;
   logic is_free_head;
   logic key_hit;
   logic read_hit;

   // This cell holds a live entry only below the current count.
   assign occupied     = MY_POS < count;
   assign is_free_head = MY_POS == count;
   assign key_hit      = occupied && (color_ff == up_tok.key);
   assign read_hit     = occupied && (MY_RD == {{CNT_W{1'b0}}, up_tok.read_idx});

   always_comb begin
      tok_in   = up_tok;
      slot_in  = up_slot;
      color_in = color_ff;
      if (up_tok.valid) begin
         case (up_tok.op)
            OP_ADD: begin
               if (!up_tok.matched && !up_tok.added) begin
                  if (key_hit) begin
                     tok_in.matched = 1'b1;
                     tok_in.color   = up_tok.key;
                     slot_in        = MY_SLOT;
                  end else if (is_free_head) begin
                     tok_in.added = 1'b1;
                     tok_in.color = up_tok.key;
                     slot_in      = MY_SLOT;
                     color_in     = up_tok.key;
                  end
               end
            end
            OP_LOOKUP: begin
               if (!up_tok.matched && key_hit) begin
                  tok_in.matched = 1'b1;
                  tok_in.color   = up_tok.key;
                  slot_in        = MY_SLOT;
               end
            end
            OP_READ: begin
               if (read_hit) begin
                  tok_in.color = color_ff;
                  slot_in      = MY_SLOT;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
      slot_ff  <= slot_in;
      color_ff <= color_in;
   end

   assign dn_tok  = tok_ff;
   assign dn_slot = slot_ff;

endmodule

### rtl/core/palette_builder_rgb565_core.sv
// Palette builder for RGB565 colors, organized as a chain of entry cells.
//
// Request words arrive on req_valid/req_ready/req_data. An add word truncates
// its RGB888 pixel to RGB565 and either reports the slot that already holds
// that color, appends it as a new entry, or flags it as dropped once the
// palette is full. A read word returns the entry at entry_index, and a lookup
// word returns the first slot holding lookup_color. Every result word on
// rsp_valid/rsp_ready/rsp_data also carries the entry count after the word.
//
// Each cell stores one palette entry. A query token enters cell 0 from the
// head register once the request is accepted and advances one cell per clock,
// and the result word is registered at the chain end; one request is in the
// chain at a time, so the next request waits until the last one has left
// the chain. The chain length is what sets both the delay to a result and
// the spacing between requests.
//
// Reset empties the palette by clearing the count; entry storage is not
// cleared since entries at or above the count are never reported. A stalled
// receiver does not stop the chain: a finished word waits in a one-word hold
// register, and the next request is accepted once the chain is empty and the hold register is free.
module palette_builder_rgb565_core import pbr_pkg::*; #(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  pbr_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output pbr_rsp_type rsp_data
);

   localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(PALETTE_DEPTH);

   // Token chain: index 0 is the head register, index PALETTE_DEPTH the tail.
   pbr_token_type      tok  [PALETTE_DEPTH+1];
   logic [IDX_W-1:0]   slot [PALETTE_DEPTH+1];
   logic [PALETTE_DEPTH:0] tok_busy;

   pbr_token_type      head_ff;
   pbr_token_type      head_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               in_flight_ff;
   logic               in_flight_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   pbr_rsp_type        rsp_data_ff;
   pbr_rsp_type        rsp_data_in;
   logic               hold_valid_ff;
   logic               hold_valid_in;
   pbr_rsp_type        hold_ff;
   pbr_rsp_type        hold_in;

   logic               req_accept;
   logic               out_free;
   pbr_token_type      tail;
   pbr_rsp_type        result;
   logic [CNT_W-1:0]   count_after;
   logic [IDX_W+INDEX_W-1:0] slot_wide;
   logic [CNT_W+COUNT_W-1:0] count_wide;

   function automatic logic [COLOR_W-1:0] pack565(
      input logic [CHAN_W-1:0] r,
      input logic [CHAN_W-1:0] g,
      input logic [CHAN_W-1:0] b
   );
      logic [CHAN_W-1:0] rm;
      logic [CHAN_W-1:0] gm;
      logic [CHAN_W-1:0] bm;
      rm = r & RB_MASK;
      gm = g & G_MASK;
      bm = b & RB_MASK;
      return {rm[7:3], gm[7:2], bm[7:3]};
   endfunction

   // Only one request lives in the chain, and the hold register must be free
   // so that the finished word always has a place to land.
   assign req_ready  = !in_flight_ff && !hold_valid_ff;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      head_in          = '0;
      head_in.valid    = req_accept;
      head_in.op       = req_data.operation;
      head_in.read_idx = req_data.entry_index;
      if (req_data.operation == OP_ADD) begin
         head_in.key = pack565(req_data.red, req_data.green, req_data.blue);
      end else begin
         head_in.key = req_data.lookup_color;
      end
   end

   assign tok[0]  = head_ff;
   assign slot[0] = '0;

   for (genvar i = 0; i < PALETTE_DEPTH; i++) begin : g_cell
      pbr_cell #(
         .IDX_W    (IDX_W),
         .CNT_W    (CNT_W),
         .CELL_IDX (i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .count   (count_ff),
         .up_tok  (tok[i]),
         .up_slot (slot[i]),
         .dn_tok  (tok[i+1]),
         .dn_slot (slot[i+1])
      );
   end

   for (genvar i = 0; i <= PALETTE_DEPTH; i++) begin : g_busy
      assign tok_busy[i] = tok[i].valid;
   end

   // Result formation at the end of the chain. The slot and color stay zero
   // unless some cell claimed the token, which covers misses and reads at or
   // beyond the count.
   assign tail        = tok[PALETTE_DEPTH];
   assign count_after = count_ff + CNT_W'(tail.added);
   assign slot_wide   = {{INDEX_W{1'b0}}, slot[PALETTE_DEPTH]};
   assign count_wide  = {{COUNT_W{1'b0}}, count_after};

   always_comb begin
      result               = '0;
      result.palette_index = slot_wide[INDEX_W-1:0];
      result.matched       = tail.matched;
      result.added         = tail.added;
      result.dropped       = (tail.op == OP_ADD) && !tail.matched && !tail.added;
      result.entry_color   = tail.color;
      result.entry_count   = count_wide[COUNT_W-1:0];
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      count_in      = tail.valid ? count_after : count_ff;
      in_flight_in  = in_flight_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;

      if (req_accept) begin
         in_flight_in = 1'b1;
      end else if (tail.valid) begin
         in_flight_in = 1'b0;
      end

      if (out_free) begin
         if (hold_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = hold_ff;
            hold_valid_in = 1'b0;
         end else if (tail.valid) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = result;
         end
      end else if (tail.valid) begin
         hold_valid_in = 1'b1;
         hold_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.valid <= 1'b0;
         count_ff      <= '0;
         in_flight_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         head_ff       <= head_in;
         count_ff      <= count_in;
         in_flight_ff  <= in_flight_in;
         rsp_valid_ff  <= rsp_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      hold_ff     <= hold_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // At most one query token travels the chain at any time.
   a_single_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_busy))
      else $error("more than one token in the cell chain");

   // The count never passes the palette depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("palette count beyond depth");

   // A word waits in the hold register only behind a pending output word.
   a_hold_behind_out: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> rsp_valid_ff)
      else $error("hold register filled while output register empty");

   // A result reports at most one of match, append and drop.
   a_one_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0({rsp_data_ff.matched, rsp_data_ff.added,
                                 rsp_data_ff.dropped}))
      else $error("conflicting outcome flags in result word");

   // A token leaves the chain only while a request is marked in flight.
   a_tail_in_flight: assert property (@(posedge clock) disable iff (reset)
      tail.valid |-> in_flight_ff)
      else $error("token at chain end without a request in flight");

endmodule
